>>> hw/rtl/session_table_aging_eviction_core_assert.svh
// Assertion macros used by the session table core.
`ifndef SESSION_TABLE_AGING_EVICTION_CORE_ASSERT_SVH
`define SESSION_TABLE_AGING_EVICTION_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define STA_ASSERT_IMPLY(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

// Check that a condition implies a consequence in the following cycle.
`define STA_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/sta_pkg.sv
package sta_pkg;

	localparam int TableEntries = 16;
	localparam int KeyBits = 64;
	localparam int IdxBits = $clog2(TableEntries);
	localparam int CntBits = $clog2(TableEntries + 1);
	localparam int CfgBits = 31;
	localparam int PendBits = 15;

	localparam logic [1:0] OP_APPLY = 2'd0;
	localparam logic [1:0] OP_PRUNE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_ACTIVE = 3'd1;
	localparam logic [2:0] ST_BGTASK = 3'd2;
	localparam logic [2:0] ST_WAIT_USER = 3'd3;
	localparam logic [2:0] ST_ALERT = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	localparam logic [1:0] CFG_IDLE_TTL = 2'd0;
	localparam logic [1:0] CFG_WORKING_TTL = 2'd1;
	localparam logic [1:0] CFG_DONE_LINGER = 2'd2;
	localparam logic [1:0] CFG_BG_HOLD = 2'd3;

	// One table entry as held in the datapath.
	typedef struct packed {
		logic [KeyBits-1:0] key;
		logic [2:0] state;
		logic [31:0] order;
		logic [31:0] updated;
		logic [31:0] ended;
		logic has_ended;
		logic [PendBits-1:0] pending;
		logic bg_armed;
		logic [31:0] bg_until;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input word
		logic scan_clr;   // reset the scan index
		logic scan_inc;   // step the scan index
		logic evict;      // move last entry into the victim slot
		logic drop;       // move last entry into the scan slot
		logic create;     // append a fresh entry
		logic update;     // apply the update to the found entry
		logic clear_all;  // empty the table
		logic finish;     // load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic key_zero;
		logic scan_done;
		logic hit;
		logic full;
		logic drop_now;
	} stat_t;

	// Urgency of a display state for eviction.
	function automatic logic [1:0] urgency(input logic [2:0] st);
		logic [1:0] u;
		u = 2'd0;
		unique case (st)
			ST_DONE: u = 2'd1;
			ST_WAIT_USER: u = 2'd2;
			ST_ALERT: u = 2'd3;
			default: u = 2'd0;
		endcase
		return u;
	endfunction

endpackage

>>> hw/rtl/sta_datapath.sv
module sta_datapath import sta_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	input logic scan_set,
	output stat_t stat,
	input logic [1:0] operation,
	input logic [KeyBits-1:0] session_key,
	input logic [31:0] now_ms,
	input logic [2:0] new_state,
	input logic signed [15:0] pending_delta,
	input logic background_ping,
	input logic clear_pending,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic cfg_ok,
	input logic [CfgBits-1:0] cfg_data,
	output logic [CntBits-1:0] entry_count,
	output logic was_ignored,
	output logic was_created,
	output logic was_evicted,
	output logic [KeyBits-1:0] evicted_key,
	output logic [CntBits-1:0] dropped_count,
	output logic [2:0] shown_state
);

	entry_t tbl_q [TableEntries];
	logic [CntBits-1:0] live_q;
	logic [31:0] order_q;
	logic [CfgBits-1:0] idle_ttl_q, work_ttl_q, linger_q, hold_q;

	logic [1:0] op_q;
	logic [KeyBits-1:0] key_q;
	logic [31:0] now_q;
	logic [2:0] nst_q;
	logic signed [15:0] delta_q;
	logic ping_q, clr_q;

	logic [CntBits-1:0] scan_q;
	logic [IdxBits-1:0] hit_idx_q, vict_q;
	logic hit_q;
	logic [1:0] vurg_q;
	logic [31:0] vage_q;
	logic created_q, evicted_q;
	logic [KeyBits-1:0] ekey_q;
	logic [CntBits-1:0] dropped_q;

	logic [IdxBits-1:0] sidx;
	entry_t cur;
	entry_t last;
	logic [2:0] cur_shown;
	logic [1:0] cur_urg;
	logic [31:0] cur_age;
	logic drop_now;
	logic [31:0] ttl;
	logic [IdxBits-1:0] last_idx;
	logic [CntBits-1:0] live_m1;
	logic [IdxBits-1:0] upd_idx;
	entry_t upd_in, upd_out;
	logic signed [16:0] psum;

	assign sidx = scan_q[IdxBits-1:0];
	assign cur = tbl_q[sidx];
	assign live_m1 = live_q - 1'b1;
	assign last_idx = live_m1[IdxBits-1:0];
	assign last = tbl_q[last_idx];

	// Display state of the entry under the scan index.
	always_comb begin
		logic [31:0] d;
		d = cur.bg_until - now_q;
		if (cur.state == ST_ALERT || cur.state == ST_DONE) cur_shown = cur.state;
		else if (cur.pending != '0) cur_shown = ST_BGTASK;
		else if (cur.bg_armed && !d[31] && d != '0) cur_shown = ST_BGTASK;
		else cur_shown = cur.state;
	end
	assign cur_urg = urgency(cur_shown);
	assign cur_age = now_q - cur.updated;

	// Aging test for prune.
	always_comb begin
		logic [31:0] a;
		if (cur.state == ST_DONE && cur.has_ended) begin
			a = now_q - cur.ended;
			ttl = {1'b0, linger_q};
		end else begin
			a = cur_age;
			ttl = (cur.state == ST_ACTIVE) ? {1'b0, work_ttl_q} : {1'b0, idle_ttl_q};
		end
		drop_now = !a[31] && (a > ttl);
	end

	// Update of the target entry.
	assign upd_idx = hit_q ? hit_idx_q : last_idx;
	always_comb begin
		upd_in = tbl_q[upd_idx];
		upd_out = upd_in;
		if (clr_q) begin
			upd_out.pending = '0;
			upd_out.bg_armed = 1'b0;
		end
		psum = $signed({2'b00, upd_out.pending}) + 17'(delta_q);
		if (delta_q != 0) begin
			if (psum < 0) upd_out.pending = '0;
			else if (psum > 17'sd32767) upd_out.pending = '1;
			else upd_out.pending = psum[PendBits-1:0];
		end
		if (ping_q) begin
			upd_out.bg_until = now_q + {1'b0, hold_q};
			upd_out.bg_armed = 1'b1;
		end
		upd_out.updated = now_q;
		if (nst_q != ST_NONE) begin
			upd_out.state = nst_q;
			upd_out.has_ended = (nst_q == ST_DONE);
			if (nst_q == ST_DONE) upd_out.ended = now_q;
		end
	end

	assign stat.op = op_q;
	assign stat.key_zero = (key_q == '0);
	assign stat.scan_done = (scan_q >= live_q);
	assign stat.hit = hit_q;
	assign stat.full = (live_q >= CntBits'(TableEntries));
	assign stat.drop_now = drop_now;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_ttl_q <= CfgBits'(1800000);
			work_ttl_q <= CfgBits'(600000);
			linger_q <= CfgBits'(60000);
			hold_q <= CfgBits'(30000);
		end else if (cfg_we && cfg_ok) begin
			unique case (cfg_idx)
				CFG_IDLE_TTL: idle_ttl_q <= cfg_data;
				CFG_WORKING_TTL: work_ttl_q <= cfg_data;
				CFG_DONE_LINGER: linger_q <= cfg_data;
				CFG_BG_HOLD: hold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input capture, scan and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			order_q <= '0;
			scan_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				op_q <= operation;
				key_q <= session_key;
				now_q <= now_ms;
				nst_q <= (new_state > ST_DONE) ? ST_NONE : new_state;
				delta_q <= pending_delta;
				ping_q <= background_ping;
				clr_q <= clear_pending;
				hit_q <= 1'b0;
				created_q <= 1'b0;
				evicted_q <= 1'b0;
				ekey_q <= '0;
				dropped_q <= '0;
				vict_q <= '0;
			end
			if (cmd.scan_clr) scan_q <= '0;
			else if (scan_set) scan_q <= CntBits'(upd_idx);
			else if (cmd.scan_inc) begin
				scan_q <= scan_q + 1'b1;
				// Lookup match and eviction candidate tracking.
				if (op_q == OP_APPLY && !hit_q && cur.key == key_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= sidx;
				end
				if (scan_q == '0 || cur_urg < vurg_q ||
						(cur_urg == vurg_q && $signed(cur_age) > $signed(vage_q))) begin
					vict_q <= sidx;
					vurg_q <= cur_urg;
					vage_q <= cur_age;
				end
			end
			if (cmd.evict) begin
				tbl_q[vict_q] <= last;
				ekey_q <= tbl_q[vict_q].key;
				evicted_q <= 1'b1;
				live_q <= live_m1;
			end
			if (cmd.drop) begin
				tbl_q[sidx] <= last;
				live_q <= live_m1;
				dropped_q <= dropped_q + 1'b1;
			end
			// A new entry becomes the target of the following update step.
			if (cmd.create) begin
				tbl_q[live_q[IdxBits-1:0]] <= '{key: key_q, state: ST_ACTIVE,
					order: order_q + 1'b1, updated: now_q, ended: '0, has_ended: 1'b0,
					pending: '0, bg_armed: 1'b0, bg_until: '0};
				order_q <= order_q + 1'b1;
				live_q <= live_q + 1'b1;
				created_q <= 1'b1;
				hit_q <= 1'b1;
				hit_idx_q <= live_q[IdxBits-1:0];
			end
			if (cmd.update) begin
				tbl_q[upd_idx] <= upd_out;
				hit_idx_q <= upd_idx;
			end
			if (cmd.clear_all) begin
				dropped_q <= live_q;
				live_q <= '0;
			end
		end
	end

	// Result register; scan index points at the applied entry at finish.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			entry_count <= live_q;
			was_ignored <= (op_q == OP_APPLY) && (key_q == '0);
			was_created <= created_q;
			was_evicted <= evicted_q;
			evicted_key <= ekey_q;
			dropped_count <= dropped_q;
			shown_state <= (op_q == OP_APPLY && key_q != '0) ? cur_shown : ST_NONE;
		end
	end

endmodule

>>> hw/rtl/sta_ctrl.sv
module sta_ctrl import sta_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input stat_t stat,
	output cmd_t cmd,
	output logic set_scan
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_APPLY = 3'd2;
	localparam logic [2:0] S_UPDATE = 3'd3;
	localparam logic [2:0] S_PRUNE = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0] state_q, state_d;
	logic out_valid_q;
	logic start;

	assign out_valid = out_valid_q;
	assign in_ready = (state_q == S_IDLE);
	assign start = in_valid && in_ready;

	// Next state and command decode.
	always_comb begin
		cmd = '0;
		set_scan = 1'b0;
		state_d = state_q;
		cmd.load = start;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (stat.op == OP_PRUNE) state_d = S_PRUNE;
				else if (stat.op == OP_CLEAR) begin
					cmd.clear_all = 1'b1;
					state_d = S_FINISH;
				end else if (stat.op != OP_APPLY || stat.key_zero) state_d = S_FINISH;
				else if (stat.scan_done || stat.hit) state_d = S_APPLY;
				else cmd.scan_inc = 1'b1;
			end
			S_APPLY: begin
				if (!stat.hit) begin
					if (stat.full) cmd.evict = 1'b1;
					state_d = S_UPDATE;
				end else state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (!stat.hit && !stat.full) begin
					cmd.create = 1'b1;
				end else begin
					cmd.update = 1'b1;
					set_scan = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_PRUNE: begin
				if (stat.scan_done) state_d = S_FINISH;
				else if (stat.drop_now) cmd.drop = 1'b1;
				else cmd.scan_inc = 1'b1;
			end
			// The result register is loaded once the previous word has left it.
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/session_table_aging_eviction_core.sv
// Apply and prune walk the 16 table entries serially, one entry per cycle; a prune holds its
// index while it drops an entry, and an apply walk stops at a matching key.
// Throughput: one word in flight; the next word is accepted in the cycle after a result is
// loaded, and waits in its finish step while the previous result is not yet taken.
// Reset: arst_n clears the entry count, order counter, controller and restores
// the configuration reset values; table contents stay undefined until written.
module session_table_aging_eviction_core import sta_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] operation,
	input logic [KeyBits-1:0] session_key,
	input logic [31:0] now_ms,
	input logic [2:0] new_state,
	input logic signed [15:0] pending_delta,
	input logic background_ping,
	input logic clear_pending,
	output logic out_valid,
	input logic out_ready,
	output logic [CntBits-1:0] entry_count,
	output logic was_ignored,
	output logic was_created,
	output logic was_evicted,
	output logic [KeyBits-1:0] evicted_key,
	output logic [CntBits-1:0] dropped_count,
	output logic [2:0] shown_state,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [CfgBits-1:0] cfg_data
);

	`include "session_table_aging_eviction_core_assert.svh"

	cmd_t cmd;
	stat_t stat;
	logic set_scan;
	cmd_t dp_cmd;

	// The update step leaves the target index in the scan register for finish.
	always_comb begin
		dp_cmd = cmd;
	end

	sta_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd),
		.set_scan(set_scan)
	);

	sta_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(dp_cmd), .stat(stat),
		.operation(operation), .session_key(session_key), .now_ms(now_ms),
		.new_state(new_state), .pending_delta(pending_delta),
		.background_ping(background_ping), .clear_pending(clear_pending),
		.cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_ok(1'b1), .cfg_data(cfg_data),
		.entry_count(entry_count), .was_ignored(was_ignored),
		.was_created(was_created), .was_evicted(was_evicted),
		.evicted_key(evicted_key), .dropped_count(dropped_count),
		.shown_state(shown_state), .scan_set(set_scan)
	);

	`STA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`STA_ASSERT_NEXT(a_key_hold, clk, arst_n, out_valid && !out_ready, $stable(evicted_key))
	`STA_ASSERT_NEXT(a_count_bound, clk, arst_n, out_valid, entry_count <= 5'd16)
	`STA_ASSERT_IMPLY(a_evict_creates, clk, arst_n, out_valid && was_evicted, was_created)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench import sta_pkg::*;;

	// One request word and one status word as the testbench keeps them.
	typedef struct packed {
		logic [1:0] op;
		logic [63:0] key;
		logic [31:0] now;
		logic [2:0] nst;
		logic signed [15:0] delta;
		logic ping;
		logic clr;
	} request_t;

	typedef struct packed {
		logic [4:0] count;
		logic ignored;
		logic created;
		logic evicted;
		logic [63:0] ekey;
		logic [4:0] dropped;
		logic [2:0] shown;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = '0;
	logic [63:0] session_key = '0;
	logic [31:0] now_ms = '0;
	logic [2:0] new_state = '0;
	logic signed [15:0] pending_delta = '0;
	logic background_ping = 1'b0;
	logic clear_pending = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CntBits-1:0] entry_count;
	logic was_ignored, was_created, was_evicted;
	logic [KeyBits-1:0] evicted_key;
	logic [CntBits-1:0] dropped_count;
	logic [2:0] shown_state;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CfgBits-1:0] cfg_data = '0;

	session_table_aging_eviction_core uut (.*);

	always #4 clk = ~clk;

	// Shadow copy of the session table.
	logic [63:0] tbl_key [TableEntries];
	logic [2:0] tbl_state [TableEntries];
	logic [31:0] tbl_updated [TableEntries];
	logic [31:0] tbl_ended [TableEntries];
	logic tbl_has_ended [TableEntries];
	logic [14:0] tbl_pending [TableEntries];
	logic tbl_bg_armed [TableEntries];
	logic [31:0] tbl_bg_until [TableEntries];
	int live;
	logic [30:0] idle_ttl = 31'd1800000, work_ttl = 31'd600000;
	logic [30:0] linger = 31'd60000, bg_hold = 31'd30000;

	request_t pending_words [$];
	status_t expected_status [$];
	int errors = 0;
	int accepted = 0, checked = 0, evictions = 0, drops = 0;
	bit quiet = 0;
	bit hold_rx = 0;
	int rx_hold_cycles = 0;

	function automatic logic [2:0] display_state(int i, logic [31:0] now);
		logic [31:0] d;
		d = tbl_bg_until[i] - now;
		if (tbl_state[i] == ST_ALERT || tbl_state[i] == ST_DONE) return tbl_state[i];
		if (tbl_pending[i] != '0) return ST_BGTASK;
		if (tbl_bg_armed[i] && !d[31] && d != '0) return ST_BGTASK;
		return tbl_state[i];
	endfunction

	function automatic int urgency_rank(logic [2:0] st);
		case (st)
			ST_DONE: return 1;
			ST_WAIT_USER: return 2;
			ST_ALERT: return 3;
			default: return 0;
		endcase
	endfunction

	function automatic void move_slot(int dst, int src);
		tbl_key[dst] = tbl_key[src];
		tbl_state[dst] = tbl_state[src];
		tbl_updated[dst] = tbl_updated[src];
		tbl_ended[dst] = tbl_ended[src];
		tbl_has_ended[dst] = tbl_has_ended[src];
		tbl_pending[dst] = tbl_pending[src];
		tbl_bg_armed[dst] = tbl_bg_armed[src];
		tbl_bg_until[dst] = tbl_bg_until[src];
	endfunction

	// Computes the status word of a request and updates the shadow table.
	function automatic status_t apply_request(request_t r);
		status_t s;
		int idx, v, p;
		logic [2:0] nst;
		logic signed [31:0] age_i, age_v, age;
		logic [31:0] lim;
		bit drop;
		s = '0;
		nst = (r.nst > ST_DONE) ? ST_NONE : r.nst;
		if (r.op == OP_APPLY) begin
			if (r.key == '0) begin
				s.ignored = 1'b1;
			end else begin
				idx = -1;
				for (int i = 0; i < live; i++)
					if (idx < 0 && tbl_key[i] == r.key) idx = i;
				if (idx < 0) begin
					if (live >= TableEntries) begin
						v = 0;
						for (int i = 1; i < live; i++) begin
							age_i = r.now - tbl_updated[i];
							age_v = r.now - tbl_updated[v];
							if (urgency_rank(display_state(i, r.now)) <
									urgency_rank(display_state(v, r.now)) ||
									(urgency_rank(display_state(i, r.now)) ==
									urgency_rank(display_state(v, r.now)) && age_i > age_v))
								v = i;
						end
						s.evicted = 1'b1;
						s.ekey = tbl_key[v];
						move_slot(v, live - 1);
						live--;
					end
					idx = live++;
					s.created = 1'b1;
					tbl_key[idx] = r.key;
					tbl_state[idx] = ST_ACTIVE;
					tbl_ended[idx] = '0;
					tbl_has_ended[idx] = 1'b0;
					tbl_pending[idx] = '0;
					tbl_bg_armed[idx] = 1'b0;
					tbl_bg_until[idx] = '0;
				end
				if (r.clr) begin
					tbl_pending[idx] = '0;
					tbl_bg_armed[idx] = 1'b0;
				end
				p = int'(tbl_pending[idx]) + int'(r.delta);
				if (p < 0) p = 0;
				if (p > 32767) p = 32767;
				tbl_pending[idx] = p[14:0];
				if (r.ping) begin
					tbl_bg_until[idx] = r.now + {1'b0, bg_hold};
					tbl_bg_armed[idx] = 1'b1;
				end
				tbl_updated[idx] = r.now;
				if (nst != ST_NONE) begin
					tbl_state[idx] = nst;
					tbl_has_ended[idx] = (nst == ST_DONE);
					if (nst == ST_DONE) tbl_ended[idx] = r.now;
				end
				s.shown = display_state(idx, r.now);
			end
		end else if (r.op == OP_PRUNE) begin
			v = 0;
			while (v < live) begin
				if (tbl_state[v] == ST_DONE && tbl_has_ended[v]) begin
					age = r.now - tbl_ended[v];
					lim = {1'b0, linger};
				end else begin
					age = r.now - tbl_updated[v];
					lim = {1'b0, (tbl_state[v] == ST_ACTIVE) ? work_ttl : idle_ttl};
				end
				drop = age > $signed(lim);
				if (drop) begin
					move_slot(v, live - 1);
					live--;
					s.dropped++;
				end else begin
					v++;
				end
			end
		end else if (r.op == OP_CLEAR) begin
			s.dropped = live[4:0];
			live = 0;
		end
		s.count = live[4:0];
		return s;
	endfunction

	// Driver: offers queued words, with random idle bursts.
	int tx_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				accepted++;
				expected_status.push_back(apply_request({operation, session_key, now_ms,
					new_state, pending_delta, background_ping, clear_pending}));
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					request_t r;
					r = pending_words.pop_front();
					in_valid <= 1'b1;
					{operation, session_key, now_ms, new_state, pending_delta,
						background_ping, clear_pending} <= r;
					if (!quiet && $urandom_range(0, 5) == 0) tx_gap <= $urandom_range(1, 4);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each result word with the oldest expectation.
	int rx_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				status_t got, want;
				got = {entry_count, was_ignored, was_created, was_evicted, evicted_key,
					dropped_count, shown_state};
				checked++;
				if (expected_status.size() == 0) begin
					errors++;
					$display("%0t: unexpected word %h", $time, got);
				end else begin
					want = expected_status.pop_front();
					evictions += want.evicted;
					drops += want.dropped;
					if (got.count !== want.count)
						$display("%0t: entry_count exp %0d got %0d", $time, want.count, got.count);
					if (got.ignored !== want.ignored)
						$display("%0t: was_ignored exp %0d got %0d", $time, want.ignored, got.ignored);
					if (got.created !== want.created)
						$display("%0t: was_created exp %0d got %0d", $time, want.created, got.created);
					if (got.evicted !== want.evicted)
						$display("%0t: was_evicted exp %0d got %0d", $time, want.evicted, got.evicted);
					if (got.ekey !== want.ekey)
						$display("%0t: evicted_key exp %h got %h", $time, want.ekey, got.ekey);
					if (got.dropped !== want.dropped)
						$display("%0t: dropped_count exp %0d got %0d", $time, want.dropped,
							got.dropped);
					if (got.shown !== want.shown)
						$display("%0t: shown_state exp %0d got %0d", $time, want.shown, got.shown);
					if (got !== want) errors++;
				end
			end
			if (hold_rx) begin
				rx_hold_cycles++;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0) rx_gap <= $urandom_range(1, 4);
			end
		end
	end

	logic [63:0] key_pool [8];
	logic [31:0] clock_ms;

	function automatic request_t make_apply(logic [63:0] k, logic [31:0] t);
		request_t r;
		r.op = OP_APPLY;
		r.key = k;
		r.now = t;
		r.nst = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 5))
			0: r.delta = 16'sh7fff;
			1: r.delta = 16'sh8000;
			2: r.delta = '0;
			3: r.delta = 16'($urandom);
			default: r.delta = $signed(16'($urandom_range(0, 6))) - 16'sd3;
		endcase
		r.ping = 1'($urandom_range(0, 1));
		r.clr = $urandom_range(0, 3) == 0;
		return r;
	endfunction

	function automatic request_t make_control(logic [1:0] op, logic [31:0] t);
		request_t r;
		r = '0;
		r.op = op;
		r.now = t;
		r.key = {$urandom, $urandom};
		r.nst = 3'($urandom);
		r.delta = 16'($urandom);
		r.ping = 1'($urandom);
		r.clr = 1'($urandom);
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid || expected_status.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [30:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_IDLE_TTL: idle_ttl = val;
			CFG_WORKING_TTL: work_ttl = val;
			CFG_DONE_LINGER: linger = val;
			default: bg_hold = val;
		endcase
	endtask

	// Queues a burst of random words: applies with fresh, reused and zero keys, plus prune, clear and unused ops.
	task automatic random_phase(int n);
		request_t r;
		int pick;
		for (int i = 0; i < n; i++) begin
			clock_ms += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40000);
			pick = $urandom_range(0, 19);
			if (pick == 0) r = make_control(OP_CLEAR, clock_ms);
			else if (pick < 3) r = make_control(OP_PRUNE, clock_ms);
			else if (pick == 3) r = make_control(2'd3, clock_ms);
			else if (pick == 4) r = make_apply(64'd0, clock_ms);
			else if (pick < 12) r = make_apply(key_pool[$urandom_range(0, 7)], clock_ms);
			else r = make_apply({$urandom, $urandom} | 64'd1, clock_ms);
			pending_words.push_back(r);
		end
	endtask

	initial begin
		request_t r;
		for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom} | 64'd1;
		key_pool[0] = '1;
		key_pool[1] = 64'h8000_0000_0000_0000;
		clock_ms = 32'hffff_f000;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ignored key, every state, pending limits, wrap of time, overflow.
		pending_words.push_back(make_apply(64'd0, 32'd0));
		for (int s = 0; s < 8; s++) begin
			r = make_apply(key_pool[s], clock_ms + s * 32'h1000);
			r.nst = 3'(s);
			r.delta = (s % 2) ? 16'sh7fff : 16'sh8000;
			pending_words.push_back(r);
		end
		for (int i = 0; i < 10; i++)
			pending_words.push_back(make_apply({$urandom, $urandom} | 64'd1, 32'd100 + i));
		pending_words.push_back(make_control(2'd3, 32'd200));
		pending_words.push_back(make_control(OP_PRUNE, 32'h7fff_ff00));
		pending_words.push_back(make_control(OP_CLEAR, 32'h8000_0000));
		wait_drained();

		// Extreme settings, then a run with zero lifetimes.
		write_reg(CFG_IDLE_TTL, '1);
		write_reg(CFG_WORKING_TTL, '1);
		write_reg(CFG_DONE_LINGER, '1);
		write_reg(CFG_BG_HOLD, '1);
		random_phase(300);
		wait_drained();
		write_reg(CFG_IDLE_TTL, 31'd0);
		write_reg(CFG_WORKING_TTL, 31'd0);
		write_reg(CFG_DONE_LINGER, 31'd0);
		write_reg(CFG_BG_HOLD, 31'd0);
		random_phase(200);

		// Long receiver stall while the sender keeps offering words.
		hold_rx = 1;
		while (rx_hold_cycles < 300) @(posedge clk);
		hold_rx = 0;
		wait_drained();

		write_reg(CFG_IDLE_TTL, 31'd90000);
		write_reg(CFG_WORKING_TTL, 31'd40000);
		write_reg(CFG_DONE_LINGER, 31'd20000);
		write_reg(CFG_BG_HOLD, 31'd50000);
		random_phase(600);
		wait_drained();
		quiet = 1;
		random_phase(400);
		wait_drained();

		$display("Covered %0d words, %0d evictions, %0d entries dropped by prune or clear.",
			checked, evictions, drops);
		if (errors == 0 && expected_status.size() == 0 && checked == accepted)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
